// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the cache RTL.
// Expects clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond holds at every edge out of reset
`define CBQ_ASSERT_NOW(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// a at an edge implies c at the same edge
`define CBQ_ASSERT_IMP(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) else $error(msg);

`endif

// ===== rtl/cbq_pkg.sv =====
// Types, codes and byte helpers for the blocking cache.
// No dependencies; imported by every cache module.
package cbq_pkg;

	typedef enum logic [3:0] {
		S_IDLE, S_SERVE, S_LOOK, S_CMP, S_HIT, S_MISS, S_LFSR, S_MOD,
		S_WBRD, S_WB, S_INST, S_REJ, S_ERR, S_DRAIN, S_DONE
	} state_t;

	localparam logic [2:0] K_RESP  = 3'd0;
	localparam logic [2:0] K_MEMRD = 3'd1;
	localparam logic [2:0] K_MEMWR = 3'd2;
	localparam logic [2:0] K_WB    = 3'd3;
	localparam logic [2:0] K_REJ   = 3'd4;
	localparam logic [2:0] K_ERR   = 3'd5;

	localparam logic CFG_QLIMIT = 1'b0;
	localparam logic CFG_SEED   = 1'b1;

	localparam int TAG_W = 29;

	typedef struct packed {
		logic [31:0] addr;
		logic [3:0]  cnt;
		logic [1:0]  port;
		logic        wr;
		logic        nr;
		logic [63:0] data;
	} req_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [1:0]  port;
		logic [31:0] addr;
		logic [63:0] data;
		logic [3:0]  cnt;
		logic        hit;
	} res_t;

	function automatic logic [63:0] byte_mask(input logic [3:0] cnt);
		if (cnt >= 4'd8)
			return '1;
		return (64'd1 << {cnt[2:0], 3'b000}) - 64'd1;
	endfunction

	function automatic logic [63:0] read_bytes(input logic [63:0] blk, input logic [2:0] off,
			input logic [3:0] cnt);
		return (blk >> {off, 3'b000}) & byte_mask(cnt);
	endfunction

	function automatic logic [63:0] write_bytes(input logic [63:0] blk, input logic [2:0] off,
			input logic [3:0] cnt, input logic [63:0] d);
		logic [63:0] m;
		m = byte_mask(cnt) << {off, 3'b000};
		return (blk & ~m) | ((d << {off, 3'b000}) & m);
	endfunction

	// taps 16,14,13,11, shifting right
	function automatic logic [15:0] lfsr_next(input logic [15:0] l);
		return {l[0] ^ l[2] ^ l[3] ^ l[5], l[15:1]};
	endfunction

endpackage

// ===== rtl/cbq_store.sv =====
// Tag and data memory of the cache lines, one write and one registered read port.
// Depends on cbq_pkg.
module cbq_store #(
	parameter int LINES = 16,
	parameter int LW    = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [LW-1:0]            waddr,
	input  logic [cbq_pkg::TAG_W-1:0] wtag,
	input  logic [63:0]              wdata,
	input  logic [LW-1:0]            raddr,
	output logic [cbq_pkg::TAG_W-1:0] rtag,
	output logic [63:0]              rdata
);
	import cbq_pkg::*;

	logic [TAG_W-1:0] tag_mem [LINES];
	logic [63:0]      data_mem [LINES];

	always_ff @(posedge clk) begin
		if (we) begin
			tag_mem[waddr]  <= wtag;
			data_mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rtag  <= tag_mem[raddr];
		rdata <= data_mem[raddr];
	end

endmodule

// ===== rtl/cbq_outbuf.sv =====
// Result buffer: holds one result back until it is known whether it is the last
// of its item, then moves it to the output register. Depends on cbq_pkg.
module cbq_outbuf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cbq_pkg::res_t res_in,
	input  logic          flush,
	output logic          ok,
	input  logic          out_ready,
	output logic          out_valid,
	output cbq_pkg::res_t out_res,
	output logic          out_last
);
	import cbq_pkg::*;

	logic pend_vld_q;
	res_t pend_q;
	logic out_vld_q;
	res_t out_q;
	logic last_q;

	assign ok        = !out_vld_q || out_ready;
	assign out_valid = out_vld_q;
	assign out_res   = out_q;
	assign out_last  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else if (ok && (push || flush) && pend_vld_q) begin
			out_vld_q  <= 1'b1;
			pend_vld_q <= push;
		end else begin
			if (out_ready)
				out_vld_q <= 1'b0;
			if (ok && push)
				pend_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ok && (push || flush) && pend_vld_q) begin
			out_q  <= pend_q;
			last_q <= !push;
		end
		if (ok && push)
			pend_q <= res_in;
	end

endmodule

// ===== rtl/blocking_cache_with_request_queue.sv =====
// Blocking fully associative write-back cache with one outstanding miss and a queue.
// A request scans the lines with one shared tag compare: an empty line takes a look step
// and a valid line a look and a compare step; an eviction adds an LFSR step, reciprocal
// remainder, victim read and writeback. One item at a time; results leave through a
// registered output. Reset clears valid bits and control at once.
module blocking_cache_with_request_queue #(
	parameter int LINES       = 16,
	parameter int QUEUE_DEPTH = 4,
	parameter int PORTS       = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [1:0]  port,
	input  logic        is_write,
	input  logic        needs_response,
	input  logic [31:0] address,
	input  logic [3:0]  byte_count,
	input  logic [63:0] payload,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [1:0]  dest_port,
	output logic [31:0] out_address,
	output logic [63:0] out_data,
	output logic [3:0]  out_count,
	output logic        was_hit,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import cbq_pkg::*;
	`include "assert_macros.svh"

	localparam int LW = $clog2(LINES);
	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int MS = 16 + LW;
	localparam logic [17:0] MREC = 18'(((64'd1 << MS) + 64'(LINES) - 64'd1) / 64'(LINES));

	state_t state_q, state_d;
	req_t   cur_q, held_q;
	logic   fill_q, held_vld_q, busy_q;
	logic [1:0]  wport_q;
	logic [2:0]  qlim_q;
	logic [15:0] lfsr_q, mod_sh_q, mod_quo_q;
	logic [LW-1:0] scan_q, inv_idx_q;
	logic        mod_cnt_q;
	logic        inv_found_q;
	logic [LINES-1:0] valid_q;
	req_t        qent_q [QUEUE_DEPTH];
	logic [QW-1:0] qhead_q;
	logic [CW-1:0] qcount_q;

	logic in_fire, room, bad, aligned, last_line, match, cur_vld, inv_any;
	logic push, flush, ok, adv, we;
	res_t res;
	logic [TAG_W-1:0] rtag;
	logic [63:0] rdata, wdata, inst_data;
	logic [CW:0] tsum;
	logic [QW-1:0] qtail;
	logic [33:0] mod_prod;
	logic [23:0] mod_qd;
	logic [LW-1:0] mod_nx;
	logic [4:0] span;
	req_t in_req;

	assign in_req    = '{addr: address, cnt: byte_count, port: port, wr: is_write,
		nr: needs_response, data: payload};
	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid && in_ready;
	assign room      = (5'(qcount_q) < 5'(qlim_q)) && (qcount_q < CW'(QUEUE_DEPTH));
	assign span      = 5'(cur_q.addr[2:0]) + 5'(cur_q.cnt);
	assign bad       = ({1'b0, cur_q.port} >= 3'(PORTS)) || (cur_q.cnt == 4'd0) ||
		(span > 5'd8);
	assign aligned   = (cur_q.addr[2:0] == 3'd0) && (cur_q.cnt == 4'd8);
	assign last_line = (scan_q == LW'(LINES - 1));
	assign cur_vld   = valid_q[scan_q];
	assign match     = (rtag == cur_q.addr[31:3]);
	assign inv_any   = inv_found_q || ((state_q == S_LOOK) && !cur_vld);
	assign tsum      = (CW+1)'(qhead_q) + (CW+1)'(qcount_q);
	assign qtail     = (tsum >= (CW+1)'(QUEUE_DEPTH)) ? QW'(tsum - (CW+1)'(QUEUE_DEPTH))
		: QW'(tsum);
	// victim = lfsr mod LINES: quotient by reciprocal multiply, then remainder
	assign mod_prod  = 34'(mod_sh_q) * 34'(MREC);
	assign mod_qd    = 24'(mod_quo_q) * 24'(LINES);
	assign mod_nx    = mod_sh_q[LW-1:0] - mod_qd[LW-1:0];
	assign inst_data = (held_vld_q && held_q.wr)
		? write_bytes(cur_q.data, held_q.addr[2:0], held_q.cnt, held_q.data) : cur_q.data;
	assign adv       = !push || ok;

	cbq_store #(.LINES(LINES), .LW(LW)) u_store (
		.clk(clk), .we(we), .waddr(scan_q), .wtag(cur_q.addr[31:3]), .wdata(wdata),
		.raddr(scan_q), .rtag(rtag), .rdata(rdata)
	);

	res_t out_res;
	cbq_outbuf u_outbuf (
		.clk(clk), .arst_n(arst_n), .push(push), .res_in(res), .flush(flush), .ok(ok),
		.out_ready(out_ready), .out_valid(out_valid), .out_res(out_res), .out_last(last)
	);
	assign kind        = out_res.kind;
	assign dest_port   = out_res.port;
	assign out_address = out_res.addr;
	assign out_data    = out_res.data;
	assign out_count   = out_res.cnt;
	assign was_hit     = out_res.hit;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (mode)
						state_d = busy_q ? S_LOOK : S_IDLE;
					else if (busy_q)
						state_d = room ? S_IDLE : S_REJ;
					else
						state_d = S_SERVE;
				end
			end
			S_SERVE: state_d = bad ? S_ERR : S_LOOK;
			S_LOOK: begin
				if (cur_vld)
					state_d = S_CMP;
				else if (last_line)
					state_d = !fill_q ? S_MISS : (inv_any ? S_INST : S_LFSR);
			end
			S_CMP: begin
				if (match)
					state_d = fill_q ? S_INST : S_HIT;
				else if (last_line)
					state_d = !fill_q ? S_MISS : (inv_any ? S_INST : S_LFSR);
				else
					state_d = S_LOOK;
			end
			S_HIT, S_MISS, S_ERR: if (adv) state_d = S_DRAIN;
			S_REJ:   if (adv) state_d = S_DONE;
			S_LFSR:  state_d = S_MOD;
			S_MOD:   if (mod_cnt_q) state_d = S_WBRD;
			S_WBRD:  state_d = S_WB;
			S_WB:    if (adv) state_d = S_INST;
			S_INST:  if (adv) state_d = S_DRAIN;
			S_DRAIN: state_d = (!busy_q && qcount_q != '0) ? S_SERVE : S_DONE;
			S_DONE:  if (ok) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		push  = 1'b0;
		flush = 1'b0;
		we    = 1'b0;
		wdata = inst_data;
		res   = '{kind: K_RESP, port: 2'd0, addr: cur_q.addr, data: 64'd0, cnt: 4'd8, hit: 1'b0};
		case (state_q)
			S_REJ: begin
				push = 1'b1;
				res  = '{kind: K_REJ, port: cur_q.port, addr: cur_q.addr, data: 64'd0,
					cnt: 4'd1, hit: 1'b0};
			end
			S_ERR: begin
				push = 1'b1;
				res  = '{kind: K_ERR, port: cur_q.port, addr: cur_q.addr, data: 64'd0,
					cnt: 4'd1, hit: 1'b0};
			end
			S_HIT: begin
				we    = cur_q.wr;
				wdata = write_bytes(rdata, cur_q.addr[2:0], cur_q.cnt, cur_q.data);
				push  = cur_q.nr;
				res   = '{kind: K_RESP, port: cur_q.port, addr: cur_q.addr,
					data: cur_q.wr ? 64'd0 : read_bytes(rdata, cur_q.addr[2:0], cur_q.cnt),
					cnt: cur_q.cnt, hit: 1'b1};
			end
			S_MISS: begin
				push = 1'b1;
				if (aligned)
					res = '{kind: cur_q.wr ? K_MEMWR : K_MEMRD, port: 2'd0, addr: cur_q.addr,
						data: cur_q.wr ? cur_q.data : 64'd0, cnt: 4'd8, hit: 1'b0};
				else
					res = '{kind: K_MEMRD, port: 2'd0, addr: {cur_q.addr[31:3], 3'b000},
						data: 64'd0, cnt: 4'd8, hit: 1'b0};
			end
			S_WB: begin
				push = 1'b1;
				res  = '{kind: K_WB, port: 2'd0, addr: {rtag, 3'b000}, data: rdata,
					cnt: 4'd8, hit: 1'b0};
			end
			S_INST: begin
				we = 1'b1;
				if (held_vld_q) begin
					push = held_q.nr;
					res  = '{kind: K_RESP, port: wport_q, addr: held_q.addr,
						data: held_q.wr ? 64'd0
							: read_bytes(inst_data, held_q.addr[2:0], held_q.cnt),
						cnt: held_q.cnt, hit: 1'b0};
				end else begin
					push = 1'b1;
					res  = '{kind: K_RESP, port: wport_q, addr: {cur_q.addr[31:3], 3'b000},
						data: held_q.wr ? 64'd0 : cur_q.data, cnt: 4'd8, hit: 1'b0};
				end
			end
			S_DONE: flush = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			busy_q      <= 1'b0;
			held_vld_q  <= 1'b0;
			wport_q     <= 2'd0;
			qlim_q      <= 3'd4;
			lfsr_q      <= 16'd1;
			valid_q     <= '0;
			qhead_q     <= '0;
			qcount_q    <= '0;
			inv_found_q <= 1'b0;
			fill_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_QLIMIT)
					qlim_q <= cfg_data[2:0];
				else
					lfsr_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						fill_q      <= mode;
						inv_found_q <= 1'b0;
						if (!mode && busy_q && room)
							qcount_q <= qcount_q + 1'b1;
					end
				end
				S_SERVE: begin
					fill_q      <= 1'b0;
					inv_found_q <= 1'b0;
				end
				S_LOOK: if (!cur_vld) inv_found_q <= 1'b1;
				S_LFSR: lfsr_q <= lfsr_next(lfsr_q);
				S_MISS: begin
					if (adv) begin
						busy_q     <= 1'b1;
						wport_q    <= cur_q.port;
						held_vld_q <= !aligned;
					end
				end
				S_INST: begin
					if (adv) begin
						valid_q[scan_q] <= 1'b1;
						busy_q          <= 1'b0;
						wport_q         <= 2'd0;
						held_vld_q      <= 1'b0;
					end
				end
				S_DRAIN: begin
					if (!busy_q && qcount_q != '0) begin
						qcount_q <= qcount_q - 1'b1;
						qhead_q  <= (qhead_q == QW'(QUEUE_DEPTH - 1)) ? '0 : qhead_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload and scan registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				scan_q <= '0;
				if (in_fire) begin
					cur_q <= in_req;
					if (!mode && busy_q && room)
						qent_q[qtail] <= in_req;
				end
			end
			S_SERVE: scan_q <= '0;
			S_LOOK: begin
				if (!cur_vld && !inv_found_q)
					inv_idx_q <= scan_q;
				if (!cur_vld && !last_line)
					scan_q <= scan_q + 1'b1;
				else if (!cur_vld && inv_found_q)
					scan_q <= inv_idx_q;
			end
			S_CMP: begin
				if (!match && !last_line)
					scan_q <= scan_q + 1'b1;
				else if (!match && inv_found_q)
					scan_q <= inv_idx_q;
			end
			S_LFSR: begin
				mod_sh_q  <= lfsr_next(lfsr_q);
				mod_cnt_q <= 1'b0;
			end
			S_MOD: begin
				mod_quo_q <= 16'(mod_prod >> MS);
				mod_cnt_q <= 1'b1;
				if (mod_cnt_q)
					scan_q <= mod_nx;
			end
			S_MISS: if (adv) held_q <= cur_q;
			S_DRAIN: if (!busy_q && qcount_q != '0) cur_q <= qent_q[qhead_q];
			default: ;
		endcase
	end

	`CBQ_ASSERT_IMP(a_held_busy, held_vld_q, busy_q, "held request without outstanding miss")
	`CBQ_ASSERT_IMP(a_serve_idle, state_q == S_SERVE, !busy_q, "request served while busy")
	`CBQ_ASSERT_NOW(a_queue_bound, qcount_q <= CW'(QUEUE_DEPTH), "queue overflow")
	`CBQ_ASSERT_IMP(a_fill_busy, state_q == S_INST, busy_q && fill_q, "install without miss")

endmodule
